>>> rtl/assert_macros.svh
// Assertion macros for the RTL files, included by the engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, cond, msg)
`define ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

>>> rtl/swrl_pkg.sv
// Shared types and constants of the sliding window rate limiter.
package swrl_pkg;
    localparam int TIME_W  = 40;
    localparam int WAIT_W  = 31;
    localparam int MODE_W  = 2;
    localparam int KEY_W   = 2;
    localparam int BURST_W = 5;
    localparam int NUM_CFG = 4;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_START = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef logic [TIME_W-1:0] t_time;
    typedef logic [WAIT_W-1:0] t_wait;
endpackage

>>> rtl/swrl_if.sv
// Request and response channel interfaces.
interface swrl_req_if import swrl_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [KEY_W-1:0]    key;
    logic [BURST_W-1:0]  burst;
    logic [TIME_W-1:0]   now_ms;
    modport source (output valid, mode, key, burst, now_ms, input ready);
    modport sink   (input valid, mode, key, burst, now_ms, output ready);
endinterface

interface swrl_rsp_if import swrl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WAIT_W-1:0] wait_ms;
    logic              log_full;
    modport source (output valid, wait_ms, log_full, input ready);
    modport sink   (input valid, wait_ms, log_full, output ready);
endinterface

>>> rtl/sliding_window_rate_limiter_unit.sv
// Top level of the sliding window rate limiter.
// Channel   Direction  Handshake
// i_req     in         valid/ready: mode, key, burst, now_ms
// o_rsp     out        valid/ready: wait_ms, log_full
// APB       in         psel/penable/pwrite, pready tied high
// Start reads log entries up to the first live one, query reads all of them,
// via the memory's single read port; clear and disabled requests read none.
// Reset is synchronous and clears all log heads, counts and intervals.
// A new item is taken while the previous result waits in the output register.
module sliding_window_rate_limiter_unit import swrl_pkg::*; #(
    parameter int NUM_KEYS  = 4,
    parameter int LOG_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    swrl_req_if.sink          i_req,
    swrl_rsp_if.source        o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);
    t_wait interval [NUM_KEYS];
    logic  clear;

    swrl_regs #(.NUM_KEYS(NUM_KEYS)) u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .i_clear(clear), .o_interval(interval)
    );

    swrl_engine #(.NUM_KEYS(NUM_KEYS), .LOG_DEPTH(LOG_DEPTH)) u_engine (
        .i_clk, .i_rst_n, .i_req, .o_rsp, .i_interval(interval), .o_clear(clear)
    );
endmodule

>>> rtl/swrl_regs.sv
// APB register bank holding the per-key interval registers.
module swrl_regs import swrl_pkg::*; #(
    parameter int NUM_KEYS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_clear,
    output t_wait             o_interval [NUM_KEYS]
);
    t_wait r_interval [NUM_KEYS];
    logic  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (!i_rst_n || i_clear) begin
                r_interval[k] <= '0;
            end else if (wr_en && k < NUM_CFG && 32'(paddr[3:2]) == k) begin
                r_interval[k] <= pwdata[WAIT_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (k < NUM_CFG && 32'(paddr[3:2]) == k) begin
                prdata = {1'b0, r_interval[k]};
            end
        end
    end

    assign o_interval = r_interval;
endmodule

>>> rtl/swrl_engine.sv
// Sequencer that walks the per-key timestamp logs held in one memory.
module swrl_engine import swrl_pkg::*; #(
    parameter int NUM_KEYS  = 4,
    parameter int LOG_DEPTH = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    swrl_req_if.sink   i_req,
    swrl_rsp_if.source o_rsp,
    input  t_wait i_interval [NUM_KEYS],
    output logic  o_clear
);
    `include "assert_macros.svh"

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int DW = $clog2(LOG_DEPTH);
    localparam int CW = $clog2(LOG_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_POP, S_PCHK, S_QRD, S_QCHK, S_CALC, S_WR, S_DONE
    } t_state;

    t_state          r_state;
    t_mode           r_mode;
    logic [KW-1:0]   r_key;
    logic [BURST_W-1:0] r_burst;
    t_time           r_now;
    t_wait           r_ivl;
    logic [CW-1:0]   r_idx;
    logic [CW-1:0]   r_recent;
    logic            r_found;
    t_time           r_age;
    t_wait           r_wait;
    logic            r_full;
    logic [DW-1:0]   r_head  [NUM_KEYS];
    logic [CW-1:0]   r_count [NUM_KEYS];
    logic            r_out_valid;
    t_wait           r_out_wait;
    logic            r_out_full;
    logic            r_clear;

    t_time           mem [NUM_KEYS][LOG_DEPTH];
    t_time           r_rd_data;
    logic            rd_en;
    logic            wr_en;
    logic [DW-1:0]   mem_idx;

    logic [DW-1:0]   head_k;
    logic [CW-1:0]   count_k;
    logic [CW-1:0]   offset;
    logic [DW:0]     sum;
    t_time           age;
    logic            expired;
    logic signed [TIME_W+1:0] diff;
    t_wait           clamped;
    logic            limited;

    assign head_k  = r_head[r_key];
    assign count_k = r_count[r_key];

    // Slot index of head plus offset, wrapped around the log depth.
    always_comb begin
        offset = (r_state == S_WR) ? count_k : r_idx;
        sum = (DW+1)'(head_k) + (DW+1)'(offset);
        if (sum >= (DW+1)'(LOG_DEPTH)) begin
            sum = sum - (DW+1)'(LOG_DEPTH);
        end
        mem_idx = sum[DW-1:0];
    end

    assign rd_en = (r_state == S_POP && count_k != '0) ||
                   (r_state == S_QRD && r_idx < count_k);
    assign wr_en = (r_state == S_WR) && (count_k < CW'(LOG_DEPTH));

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[r_key][mem_idx];
        end
        if (wr_en) begin
            mem[r_key][mem_idx] <= r_now + TIME_W'(r_wait);
        end
    end

    // Age is read as a signed 40-bit difference.
    assign age     = r_now - r_rd_data;
    assign expired = !age[TIME_W-1] && (age[TIME_W-2:0] >= (TIME_W-1)'(r_ivl));
    assign diff    = $signed({11'b0, r_ivl}) - $signed({{2{r_age[TIME_W-1]}}, r_age});
    always_comb begin
        if (diff < 0) begin
            clamped = '0;
        end else if (diff > $signed((TIME_W+2)'({WAIT_W{1'b1}}))) begin
            clamped = '1;
        end else begin
            clamped = diff[WAIT_W-1:0];
        end
    end
    assign limited = (r_mode == MODE_START)
                   ? (count_k != '0 && 32'(count_k) >= 32'(r_burst))
                   : (r_found && 32'(r_recent) >= 32'(r_burst));

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.wait_ms  = r_out_wait;
    assign o_rsp.log_full = r_out_full;
    assign o_clear        = r_clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key       <= '0;
            r_out_valid <= 1'b0;
            r_clear     <= 1'b0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_head[k]  <= '0;
                r_count[k] <= '0;
            end
        end else begin
            r_clear <= (r_state == S_IDLE) && i_req.valid && (i_req.mode == MODE_CLEAR);
            // In the result state the output register is reloaded instead.
            if (o_rsp.valid && o_rsp.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_mode   <= t_mode'(i_req.mode);
                        r_key    <= i_req.key[KW-1:0];
                        r_burst  <= i_req.burst;
                        r_now    <= i_req.now_ms;
                        r_ivl    <= i_interval[i_req.key[KW-1:0]];
                        r_idx    <= '0;
                        r_recent <= '0;
                        r_found  <= 1'b0;
                        r_wait   <= '0;
                        r_full   <= 1'b0;
                        r_state  <= S_DONE;
                        if (i_req.mode == MODE_CLEAR) begin
                            for (int k = 0; k < NUM_KEYS; k++) begin
                                r_head[k]  <= '0;
                                r_count[k] <= '0;
                            end
                        end else if ((i_req.mode == MODE_START || i_req.mode == MODE_QUERY)
                                     && 32'(i_req.key) < NUM_KEYS
                                     && i_interval[i_req.key[KW-1:0]] != '0
                                     && i_req.burst != '0) begin
                            r_state <= (i_req.mode == MODE_START) ? S_POP : S_QRD;
                        end
                    end
                end
                S_POP: begin
                    r_state <= (count_k != '0) ? S_PCHK : S_CALC;
                end
                S_PCHK: begin
                    if (expired) begin
                        r_head[r_key]  <= (32'(head_k) == LOG_DEPTH - 1)
                                          ? '0 : head_k + 1'b1;
                        r_count[r_key] <= count_k - 1'b1;
                        r_state        <= S_POP;
                    end else begin
                        r_age   <= age;
                        r_state <= S_CALC;
                    end
                end
                S_QRD: begin
                    r_state <= (r_idx < count_k) ? S_QCHK : S_CALC;
                end
                S_QCHK: begin
                    if (!expired) begin
                        r_recent <= r_recent + 1'b1;
                        if (!r_found || $signed(age) > $signed(r_age)) begin
                            r_age   <= age;
                            r_found <= 1'b1;
                        end
                    end
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_QRD;
                end
                S_CALC: begin
                    r_wait  <= limited ? clamped : '0;
                    r_state <= (r_mode == MODE_START) ? S_WR : S_DONE;
                end
                S_WR: begin
                    if (wr_en) begin
                        r_count[r_key] <= count_k + 1'b1;
                    end else begin
                        r_full <= 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_wait  <= r_wait;
                        r_out_full  <= r_full;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_ALWAYS(a_count_bound, r_count[r_key] <= CW'(LOG_DEPTH), "log count above depth")
    `ASSERT_IMPL(a_pchk_after_pop, r_state == S_PCHK, $past(r_state) == S_POP, "check without read")
    `ASSERT_IMPL(a_full_start, r_state == S_DONE && r_full, r_mode == MODE_START, "full outside start")
    `ASSERT_IMPL(a_write_start, wr_en, r_mode == MODE_START && r_state == S_WR, "stray log write")
endmodule
